[hdl/stmf_pkg.sv]
// Package for the sliding trimmed-mean filter.
// Shared widths, register indexes, controller commands and status.
// No dependencies.
package stmf_pkg;

   localparam int WINDOW_MAX_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int LEN_W      = 6;
   localparam int DROP_W     = 2;
   localparam int GAIN_W     = 16;
   localparam int OFFSET_W   = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int OUT_W      = 32;
   localparam int FRAC_BITS  = 8;

   // drop clamping
   localparam int DROP_MAX  = 2;
   localparam int LEN_DROP2 = 6;
   localparam int LEN_DROP1 = 4;

   // reset values
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LEN = 2'd0,
      CSR_DROP_COUNT = 2'd1,
      CSR_GAIN       = 2'd2,
      CSR_OFFSET     = 2'd3
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic bubble;
      logic insert;
      logic sum;
      logic mul;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic replace;
      logic out_busy;
   } status_type;

endpackage

[hdl/sliding_trimmed_mean_filter.sv]
// Sliding trimmed-mean filter, top level.
// Samples arrive on the req_ stream, one result per sample leaves on the
// rsp_ stream: filtered value in rsp_tdata, window-full flag in rsp_tuser.
// The window is held as a row of sorted cells. Once the window is full,
// the oldest entry is bubbled to the top of the filled region, one cell a
// cycle; the new sample is then inserted. The cells are summed one per
// cycle, scaled by one multiply, and divided by a restoring divider
// producing one quotient bit per cycle. A new sample is taken only in
// the idle state.
// The result sits in an output register; a new sample is accepted while
// it waits. A stalled receiver holds the next result at the last step.
// Reset (synchronous, active high) empties the window and loads the
// register defaults; any CSR write also empties the window.
// Depends on stmf_pkg, stmf_ctrl, stmf_dpath.
module sliding_trimmed_mean_filter import stmf_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,   // [SAMPLE_BITS-1:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,   // [31:0] filtered
   output logic [0:0]            rsp_tuser,   // [0] window_full
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int PROD_W = SAMPLE_BITS + CNT_W + GAIN_W;
   localparam int DIV_W  = PROD_W - 1 - FRAC_BITS;

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] step_idx;
   logic             rsp_full;

   stmf_ctrl #(
      .WINDOW_MAX (WINDOW_MAX),
      .DIV_W      (DIV_W),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .step_idx   (step_idx)
   );

   stmf_dpath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W),
      .DIV_W       (DIV_W)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .step_idx     (step_idx),
      .status       (status),
      .sample       (req_tdata[SAMPLE_BITS-1:0]),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_filtered (rsp_tdata),
      .rsp_full     (rsp_full)
   );

   assign rsp_tuser = rsp_full;

   // a transfer in starts the sequence, so the block is busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again right after a transfer");

   // at most one datapath command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.bubble, cmd.insert, cmd.sum, cmd.mul,
                cmd.div_init, cmd.div_step, cmd.finish, cmd.load}))
      else $error("overlapping datapath commands");

   // a result is written only into a free output register
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a pending output");

   // the output goes valid only through a finish step
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.finish))
      else $error("output valid without a finish step");

endmodule

[hdl/stmf_ctrl.sv]
// Controller of the sliding trimmed-mean filter.
// Sequences removal, insertion, summation, scaling and division.
// Depends on stmf_pkg.
module stmf_ctrl import stmf_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int DIV_W      = 29,
   parameter int IDX_W      = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  status_type       status,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] step_idx
);

   localparam int MAXC  = (WINDOW_MAX > DIV_W) ? WINDOW_MAX : DIV_W;
   localparam int CTR_W = (MAXC > 1) ? $clog2(MAXC) : 1;
   localparam logic [CTR_W-1:0] BUB_LAST = CTR_W'((WINDOW_MAX > 1) ? WINDOW_MAX - 2 : 0);
   localparam logic [CTR_W-1:0] SUM_LAST = CTR_W'(WINDOW_MAX - 1);
   localparam logic [CTR_W-1:0] DIV_LAST = CTR_W'(DIV_W - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_BUBBLE = 8'b0000_0010,
      ST_INSERT = 8'b0000_0100,
      ST_SUM    = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_DIVI   = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CTR_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign step_idx   = cnt_ff[IDX_W-1:0];

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = (status.replace && (WINDOW_MAX > 1)) ? ST_BUBBLE : ST_INSERT;
            end
         end
         ST_BUBBLE: begin
            cmd.bubble = 1'b1;
            if (cnt_ff == BUB_LAST) begin
               cnt_in   = '0;
               state_in = ST_INSERT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            cnt_in     = '0;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (cnt_ff == SUM_LAST) begin
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hdl/stmf_dpath.sv]
// Datapath of the sliding trimmed-mean filter: sorted window cells,
// accumulator, multiplier, restoring divider, output register and CSRs.
// Depends on stmf_pkg.
module stmf_dpath import stmf_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int IDX_W       = 5,
   parameter int CNT_W       = 6,
   parameter int DIV_W       = 29
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   input  logic [IDX_W-1:0]              step_idx,
   output status_type                    status,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          csr_wen,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [OUT_W-1:0]              rsp_filtered,
   output logic                          rsp_full
);

   localparam int W      = WINDOW_MAX;
   localparam int S      = SAMPLE_BITS;
   localparam int LX_W   = CNT_W + 3;
   localparam int LC_W   = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;
   localparam int SUM_W  = S + CNT_W;
   localparam int PROD_W = SUM_W + GAIN_W;
   localparam int R_W    = (DIV_W + 2 > OUT_W + 1) ? DIV_W + 2 : OUT_W + 1;

   localparam logic signed [R_W-1:0] SAT_MAX = R_W'({1'b0, {(OUT_W-1){1'b1}}});
   localparam logic signed [R_W-1:0] SAT_MIN = -SAT_MAX - R_W'(1);

   // window cells
   logic signed [S-1:0] val_ff [W];
   logic signed [S-1:0] val_in [W];
   logic [IDX_W-1:0]    age_ff [W];
   logic [IDX_W-1:0]    age_in [W];
   logic [W-1:0]        dead_ff, dead_in;
   logic [W-1:0]        gt;

   // control state
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  ns_ff, ns_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic signed [GAIN_W-1:0]   gain_ff, gain_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [S-1:0]      x_ff, x_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [CNT_W-1:0]         first_ff, first_in;
   logic [CNT_W-1:0]         last_ff, last_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     full_ff, full_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [OUT_W-1:0]         filt_ff, filt_in;
   logic                     rfull_ff, rfull_in;

   logic [LX_W-1:0] fillx, lenx, nx;
   assign fillx = LX_W'(fill_ff);
   assign lenx  = LX_W'(len_ff);
   assign nx    = LX_W'(n_ff);

   assign status.replace  = (fillx >= lenx);
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_filtered = filt_ff;
   assign rsp_full     = rfull_ff;

   // insertion compares, one per cell
   always_comb begin
      for (int i = 0; i < W; i++) begin
         gt[i] = (LX_W'(i) >= nx) || (val_ff[i] > x_ff);
      end
   end

   // cell next values
   for (genvar i = 0; i < W; i++) begin : g_cell
      logic signed [S-1:0] up_v, dn_v;
      logic [IDX_W-1:0]    up_a, dn_a;
      logic                dn_d, gt_dn, in_fill, up_in_fill;

      if (i < W - 1) begin : g_up
         assign up_v = val_ff[i+1];
         assign up_a = age_ff[i+1];
      end else begin : g_top
         assign up_v = val_ff[i];
         assign up_a = age_ff[i];
      end

      if (i > 0) begin : g_dn
         assign dn_v  = val_ff[i-1];
         assign dn_a  = age_ff[i-1];
         assign dn_d  = dead_ff[i-1];
         assign gt_dn = gt[i-1];
      end else begin : g_bot
         assign dn_v  = val_ff[i];
         assign dn_a  = age_ff[i];
         assign dn_d  = 1'b0;
         assign gt_dn = 1'b0;
      end

      assign in_fill    = (LX_W'(i) < fillx);
      assign up_in_fill = (LX_W'(i + 1) < fillx);

      always_comb begin
         val_in[i]  = val_ff[i];
         age_in[i]  = age_ff[i];
         dead_in[i] = dead_ff[i];
         if (cmd.load) begin
            // mark the oldest entry for removal
            dead_in[i] = status.replace && in_fill && (age_ff[i] == ns_ff);
         end else if (cmd.bubble) begin
            // move the marked entry one cell up
            if (dead_ff[i] && up_in_fill) begin
               val_in[i]  = up_v;
               age_in[i]  = up_a;
               dead_in[i] = 1'b0;
            end else if (dn_d && in_fill) begin
               val_in[i]  = dn_v;
               age_in[i]  = dn_a;
               dead_in[i] = 1'b1;
            end
         end else if (cmd.insert) begin
            // larger entries shift up, new sample lands after equal ones
            dead_in[i] = 1'b0;
            if (gt_dn) begin
               val_in[i] = dn_v;
               age_in[i] = dn_a;
            end else if (gt[i]) begin
               val_in[i] = x_ff;
               age_in[i] = ns_ff;
            end
         end
      end
   end

   // scalar datapath
   logic [LC_W-1:0]         len_req;
   logic [DROP_W-1:0]       k;
   logic [LX_W-1:0]         kx, stepx, ns_inc;
   logic signed [PROD_W-1:0] mag;
   logic [CNT_W:0]          rem_sh;
   logic signed [R_W-1:0]   qx, rx;

   always_comb begin
      fill_in      = fill_ff;
      ns_in        = ns_ff;
      len_in       = len_ff;
      drop_in      = drop_ff;
      gain_in      = gain_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      filt_in      = filt_ff;
      rfull_in     = rfull_ff;

      // window length request, zero as one, clamped to the window size
      len_req = LC_W'(csr_wdata[LEN_W-1:0]);
      if (len_req == '0) begin
         len_req = LC_W'(1);
      end
      if (len_req > LC_W'(W)) begin
         len_req = LC_W'(W);
      end

      // effective drop per end
      k = drop_ff;
      if (k >= DROP_W'(DROP_MAX)) begin
         k = DROP_W'(DROP_MAX);
         if (lenx < LX_W'(LEN_DROP2)) begin
            k = DROP_W'(1);
         end
      end
      if (lenx < LX_W'(LEN_DROP1)) begin
         k = '0;
      end
      kx     = LX_W'(k);
      stepx  = LX_W'(step_idx);
      ns_inc = LX_W'(ns_ff) + LX_W'(1);

      mag    = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      qx     = R_W'($signed({1'b0, quo_ff}));
      if (neg_ff) begin
         qx = -qx;
      end
      rx = qx + R_W'(offset_ff);

      // configuration writes restart the fill
      if (csr_wen) begin
         fill_in = '0;
         ns_in   = '0;
         case (csr_index)
            CSR_WINDOW_LEN: len_in    = len_req[CNT_W-1:0];
            CSR_DROP_COUNT: drop_in   = csr_wdata[DROP_W-1:0];
            CSR_GAIN:       gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_OFFSET:     offset_in = csr_wdata[OFFSET_W-1:0];
            default:        len_in    = len_ff;
         endcase
      end

      // transfer taken
      if (cmd.load) begin
         x_in = sample;
         if (status.replace) begin
            n_in = fill_ff - 1'b1;
         end else begin
            n_in    = fill_ff;
            fill_in = fill_ff + 1'b1;
         end
      end

      // trim bounds and ring advance
      if (cmd.insert) begin
         acc_in  = '0;
         full_in = (fillx >= lenx);
         ns_in   = (ns_inc >= lenx) ? '0 : ns_inc[IDX_W-1:0];
         if (fillx >= lenx) begin
            first_in = CNT_W'(k);
            last_in  = CNT_W'(lenx - kx - LX_W'(1));
            count_in = CNT_W'(lenx - kx - kx);
         end else begin
            first_in = '0;
            last_in  = fill_ff - 1'b1;
            count_in = fill_ff;
         end
      end

      // one cell per cycle into the accumulator
      if (cmd.sum) begin
         if ((stepx >= LX_W'(first_ff)) && (stepx <= LX_W'(last_ff))) begin
            acc_in = acc_ff + SUM_W'(val_ff[step_idx]);
         end
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(acc_ff) * PROD_W'(gain_ff);
      end

      // divide |prod| / 256 by count, one quotient bit per cycle
      if (cmd.div_init) begin
         neg_in = prod_ff[PROD_W-1];
         quo_in = mag[PROD_W-2:FRAC_BITS];
         rem_in = '0;
      end

      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, count_ff}) begin
            rem_in = CNT_W'(rem_sh - {1'b0, count_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CNT_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end

      // output register
      if (cmd.finish) begin
         if (rx > SAT_MAX) begin
            filt_in = SAT_MAX[OUT_W-1:0];
         end else if (rx < SAT_MIN) begin
            filt_in = SAT_MIN[OUT_W-1:0];
         end else begin
            filt_in = rx[OUT_W-1:0];
         end
         rfull_in     = full_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         ns_ff        <= '0;
         len_ff       <= CNT_W'(1);
         drop_ff      <= '0;
         gain_ff      <= GAIN_RESET;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         dead_ff      <= '0;
      end else begin
         fill_ff      <= fill_in;
         ns_ff        <= ns_in;
         len_ff       <= len_in;
         drop_ff      <= drop_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
         dead_ff      <= dead_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      age_ff   <= age_in;
      x_ff     <= x_in;
      n_ff     <= n_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      count_ff <= count_in;
      full_ff  <= full_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      filt_ff  <= filt_in;
      rfull_ff <= rfull_in;
   end

endmodule
